FILE: hw/rtl/tpot_pkg.sv
// Shared types and constants for the timed pending object table.
// Used by tpot_engine and timed_pending_object_table; no dependencies.
package tpot_pkg;

    // Field widths of the key, countdown and statistics.
    localparam int TYPE_W    = 10;
    localparam int INST_W    = 22;
    localparam int MS_W      = 16;
    localparam int STAT_W    = 32;
    localparam int PEND_W    = 6;
    localparam int ENTRY_W   = TYPE_W + INST_W + MS_W;

    // Reset value of the holdoff register, in milliseconds.
    localparam logic [MS_W-1:0] HOLDOFF_RESET = 16'd1000;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [MS_W-1:0]   remaining;
        logic [INST_W-1:0] instance_id;
        logic [TYPE_W-1:0] type_id;
    } entry_t;

    // One result word handed from the engine to the output register.
    typedef struct packed {
        status_t             status;
        logic                refresh_due;
        logic [STAT_W-1:0]   timeout_count;
        logic [PEND_W-1:0]   pending_count;
        logic [STAT_W-1:0]   capacity_error_count;
        logic [STAT_W-1:0]   refresh_count;
    } result_t;

endpackage

FILE: hw/rtl/timed_pending_object_table.sv
// Top level of the timed pending object table: stream ports, holdoff register, output register.
// Depends on tpot_pkg and instantiates tpot_engine.
//
// Each accepted word scans the whole table once through the entry memory, one entry per
// cycle through its registered read port, and the next word is accepted only after the
// item has passed an idle state, the scan of all TABLE_ENTRIES entries, an update state
// and a hand-off state, which waits until the output register can load. The single memory
// port pair sets this pace. A finished result waits in an output register, so the next
// word can be taken while the previous result is still unread. The valid bits are cleared
// at reset at once; no clearing pass is needed. Ticks update the countdowns in place during
// their scan; inserts write the lowest free entry after the scan.
module timed_pending_object_table #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,   // holdoff_ms
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,       // object_type[9:0], object_instance[31:10],
                                         // delta_ms[47:32]
    input  logic [1:0]    s_tuser,       // operation[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,       // refresh_due[0], timeout_count[32:1],
                                         // pending_count[38:33], capacity_error_count[70:39],
                                         // refresh_count[102:71], zero[103]
    output logic [1:0]    m_tuser        // status[1:0]
);

    logic [tpot_pkg::MS_W-1:0] holdoff_reg;
    logic                      out_valid_reg;
    tpot_pkg::result_t         out_data_reg;
    logic                      res_valid;
    logic                      res_ready;
    tpot_pkg::result_t         res;

    // Holdoff configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= tpot_pkg::HOLDOFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            holdoff_reg <= cfg_wr_data;
        end
    end

    tpot_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (tpot_pkg::op_t'(s_tuser)),
        .in_type    (s_tdata[9:0]),
        .in_inst    (s_tdata[31:10]),
        .in_elapsed (s_tdata[47:32]),
        .holdoff    (holdoff_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {1'b0,
                       out_data_reg.refresh_count,
                       out_data_reg.capacity_error_count,
                       out_data_reg.pending_count,
                       out_data_reg.timeout_count,
                       out_data_reg.refresh_due};

endmodule

FILE: hw/rtl/tpot_mem.sv
// Entry store of the timed pending object table: one write and one read port.
// Synchronous, registered read port; depends on nothing else.
module tpot_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tpot_engine.sv
// Scan engine of the timed pending object table: sequencer, valid bits and counters.
// Depends on tpot_pkg and instantiates tpot_mem for the entry store.
module tpot_engine #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tpot_pkg::op_t                in_op,
    input  logic [tpot_pkg::TYPE_W-1:0]  in_type,
    input  logic [tpot_pkg::INST_W-1:0]  in_inst,
    input  logic [tpot_pkg::MS_W-1:0]    in_elapsed,
    input  logic [tpot_pkg::MS_W-1:0]    holdoff,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tpot_pkg::result_t            res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    tpot_pkg::op_t                 op_reg, op_next;
    logic [tpot_pkg::TYPE_W-1:0]   type_reg, type_next;
    logic [tpot_pkg::INST_W-1:0]   inst_reg, inst_next;
    logic [tpot_pkg::MS_W-1:0]     elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]              rd_cnt_reg, rd_cnt_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;
    logic                          found_reg, found_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic                          due_reg, due_next;
    logic                          free_found_reg, free_found_next;
    logic [IDX_W-1:0]              free_reg, free_next;
    logic [TABLE_ENTRIES-1:0]      valid_reg, valid_next;
    logic [tpot_pkg::STAT_W-1:0]   timeouts_reg, timeouts_next;
    logic [tpot_pkg::PEND_W-1:0]   pending_reg, pending_next;
    logic [tpot_pkg::STAT_W-1:0]   cap_err_reg, cap_err_next;
    logic [tpot_pkg::STAT_W-1:0]   refresh_reg, refresh_next;
    tpot_pkg::result_t             res_reg, res_next;

    logic                          mem_rd_en;
    logic [IDX_W-1:0]              mem_rd_addr;
    tpot_pkg::entry_t              mem_rd_data;
    logic                          mem_wr_en;
    logic [IDX_W-1:0]              mem_wr_addr;
    tpot_pkg::entry_t              mem_wr_data;

    logic                          chk_valid;
    logic                          chk_match;

    // Entry store.
    tpot_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (tpot_pkg::ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    // Read issue: one entry per cycle while the scan runs.
    assign mem_rd_en   = (state_reg == S_SCAN) && (rd_cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign mem_rd_addr = rd_cnt_reg[IDX_W-1:0];

    // Check of the word returned by the memory for entry rd_idx_reg.
    assign chk_valid = rd_vld_reg && valid_reg[rd_idx_reg];
    assign chk_match = chk_valid && (mem_rd_data.type_id == type_reg)
                       && (mem_rd_data.instance_id == inst_reg);

    // Memory writes: tick write-back during the scan, new entry at the finish.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = rd_idx_reg;
        mem_wr_data = mem_rd_data;
        if (state_reg == S_SCAN)
        begin
            mem_wr_en = chk_valid && (op_reg == tpot_pkg::OP_TICK);
            if (elapsed_reg >= mem_rd_data.remaining)
            begin
                mem_wr_data.remaining = '0;
            end
            else
            begin
                mem_wr_data.remaining = mem_rd_data.remaining - elapsed_reg;
            end
        end
        else if (state_reg == S_FINISH)
        begin
            mem_wr_en   = (op_reg == tpot_pkg::OP_INSERT) && !found_reg && free_found_reg;
            mem_wr_addr = free_reg;
            mem_wr_data.type_id     = type_reg;
            mem_wr_data.instance_id = inst_reg;
            mem_wr_data.remaining   = holdoff;
        end
    end

    // Sequencer and table bookkeeping.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        type_next       = type_reg;
        inst_next       = inst_reg;
        elapsed_next    = elapsed_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        due_next        = due_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        valid_next      = valid_reg;
        timeouts_next   = timeouts_reg;
        pending_next    = pending_reg;
        cap_err_next    = cap_err_reg;
        refresh_next    = refresh_reg;
        res_next        = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_op;
                    type_next       = in_type;
                    inst_next       = in_inst;
                    elapsed_next    = in_elapsed;
                    rd_cnt_next     = '0;
                    found_next      = 1'b0;
                    due_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (mem_rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (chk_match && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = rd_idx_reg;
                    due_next   = (mem_rd_data.remaining == '0);
                end
                if (rd_vld_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = rd_idx_reg;
                end
                if (rd_vld_reg && (rd_idx_reg == IDX_W'(TABLE_ENTRIES - 1)))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                res_next.status      = tpot_pkg::ST_DONE;
                res_next.refresh_due = 1'b0;
                case (op_reg)
                    tpot_pkg::OP_INSERT:
                    begin
                        timeouts_next = timeouts_reg + 1'b1;
                        if (found_reg)
                        begin
                            res_next.status = tpot_pkg::ST_PRESENT;
                        end
                        else if (free_found_reg)
                        begin
                            valid_next[free_reg] = 1'b1;
                            pending_next         = pending_reg + 1'b1;
                        end
                        else
                        begin
                            cap_err_next    = cap_err_reg + 1'b1;
                            res_next.status = tpot_pkg::ST_FULL;
                        end
                    end
                    tpot_pkg::OP_QUERY:
                    begin
                        if (found_reg)
                        begin
                            res_next.refresh_due = due_reg;
                        end
                        else
                        begin
                            res_next.status = tpot_pkg::ST_NOT_FOUND;
                        end
                    end
                    tpot_pkg::OP_CLEAR:
                    begin
                        if (found_reg)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            pending_next         = pending_reg - 1'b1;
                            if (due_reg)
                            begin
                                refresh_next = refresh_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            res_next.status = tpot_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // Tick: the countdowns were updated during the scan.
                        res_next.status = tpot_pkg::ST_DONE;
                    end
                endcase
                res_next.timeout_count        = timeouts_next;
                res_next.pending_count        = pending_next;
                res_next.capacity_error_count = cap_err_next;
                res_next.refresh_count        = refresh_next;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_vld_reg   <= 1'b0;
            rd_cnt_reg   <= '0;
            valid_reg    <= '0;
            timeouts_reg <= '0;
            pending_reg  <= '0;
            cap_err_reg  <= '0;
            refresh_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            rd_cnt_reg   <= rd_cnt_next;
            valid_reg    <= valid_next;
            timeouts_reg <= timeouts_next;
            pending_reg  <= pending_next;
            cap_err_reg  <= cap_err_next;
            refresh_reg  <= refresh_next;
        end
    end

    // Item fields, scan results and the result word.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        type_reg       <= type_next;
        inst_reg       <= inst_next;
        elapsed_reg    <= elapsed_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        due_reg        <= due_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        res_reg        <= res_next;
    end

    // The pending counter tracks the number of valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == tpot_pkg::PEND_W'($countones(valid_reg)))
        else $error("pending counter disagrees with valid bits");

    // An accepted word always starts a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN))
        else $error("accepted word did not start a scan");

    // The read counter never runs past the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("read counter out of range");

    // Memory writes only happen while scanning or finishing an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> ((state_reg == S_SCAN) || (state_reg == S_FINISH)))
        else $error("memory write outside of an item");

endmodule
